[sv/mm_pkg.sv]
`default_nettype none
package mm_pkg;

   localparam int MAX_DIM   = 4;
   localparam int FRAC_BITS = 16;

   localparam int DATA_W  = 32;
   localparam int CFG_W   = 3;
   localparam int KIND_W  = 2;
   localparam int POS_W   = 2;
   localparam int CSR_IDX_W = 2;

   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int DIM_W  = $clog2(MAX_DIM + 1);
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
   localparam int SH_W   = ACC_W - FRAC_BITS;

   localparam int ITEM_BITS  = POS_W + POS_W + DATA_W;
   localparam int TDATA_W    = ((ITEM_BITS + 7) / 8) * 8;
   localparam int PAD_W      = TDATA_W - ITEM_BITS;

   localparam logic [KIND_W-1:0] KIND_LOAD_LEFT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_RIGHT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COMPUTE    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LEFT_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_COLS = 2'd2;

   localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

   typedef struct packed {
      logic              wr_left;
      logic              wr_right;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_left_addr;
      logic [ADDR_W-1:0] rd_right_addr;
      logic              first;
      logic              last_k;
      logic              out_load;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic              out_last;
   } cmd_type;

   typedef struct packed {
      logic acc_valid;
      logic out_busy;
   } sts_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
      logic [DIM_W-1:0] res;
      if (d == '0) begin
         res = DIM_W'(1);
      end else if (int'(d) > MAX_DIM) begin
         res = DIM_W'(MAX_DIM);
      end else begin
         res = DIM_W'(d);
      end
      return res;
   endfunction

endpackage
`default_nettype wire

[sv/mm_ram.sv]
`default_nettype none
module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[sv/mm_ctrl.sv]
`default_nettype none
module mm_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [mm_pkg::KIND_W-1:0]     req_kind,
   input  wire logic [mm_pkg::POS_W-1:0]      req_row,
   input  wire logic [mm_pkg::POS_W-1:0]      req_col,
   input  wire logic                          csr_we,
   input  wire logic [mm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mm_pkg::CFG_W-1:0]      csr_wdata,
   input  wire mm_pkg::sts_type               sts,
   output mm_pkg::cmd_type                    cmd
);

   typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_type;

   state_type                    state_ff;
   logic [mm_pkg::CFG_W-1:0]     rows_cfg_ff, inner_cfg_ff, cols_cfg_ff;
   logic [mm_pkg::DIM_W-1:0]     nr_ff, nk_ff, nc_ff;
   logic [mm_pkg::IDX_W-1:0]     r_ff, c_ff, k_ff;

   logic accept, load_ok, k_last, row_last, col_last, out_go;

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && req_tready;
      load_ok    = (int'(req_row) < mm_pkg::MAX_DIM) && (int'(req_col) < mm_pkg::MAX_DIM);
      k_last     = (int'(k_ff) + 1 == int'(nk_ff));
      row_last   = (int'(r_ff) + 1 == int'(nr_ff));
      col_last   = (int'(c_ff) + 1 == int'(nc_ff));
      out_go     = (state_ff == ST_WAIT) && sts.acc_valid && !sts.out_busy;

      cmd = '0;
      cmd.wr_left  = accept && load_ok && (req_kind == mm_pkg::KIND_LOAD_LEFT);
      cmd.wr_right = accept && load_ok && (req_kind == mm_pkg::KIND_LOAD_RIGHT);
      cmd.wr_addr  = mm_pkg::ADDR_W'(int'(req_row) * mm_pkg::MAX_DIM + int'(req_col));
      cmd.rd_en    = (state_ff == ST_ISSUE);
      cmd.rd_left_addr  = mm_pkg::ADDR_W'(int'(r_ff) * mm_pkg::MAX_DIM + int'(k_ff));
      cmd.rd_right_addr = mm_pkg::ADDR_W'(int'(k_ff) * mm_pkg::MAX_DIM + int'(c_ff));
      cmd.first    = (k_ff == '0);
      cmd.last_k   = k_last;
      cmd.out_load = out_go;
      cmd.out_row  = mm_pkg::POS_W'(r_ff);
      cmd.out_col  = mm_pkg::POS_W'(c_ff);
      cmd.out_last = row_last && col_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_cfg_ff  <= mm_pkg::CFG_RESET;
         inner_cfg_ff <= mm_pkg::CFG_RESET;
         cols_cfg_ff  <= mm_pkg::CFG_RESET;
         nr_ff        <= '0;
         nk_ff        <= '0;
         nc_ff        <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         k_ff         <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               mm_pkg::REG_LEFT_ROWS:  rows_cfg_ff  <= csr_wdata;
               mm_pkg::REG_INNER_SIZE: inner_cfg_ff <= csr_wdata;
               mm_pkg::REG_RIGHT_COLS: cols_cfg_ff  <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_kind == mm_pkg::KIND_COMPUTE)) begin
                  nr_ff    <= mm_pkg::clamp_dim(rows_cfg_ff);
                  nk_ff    <= mm_pkg::clamp_dim(inner_cfg_ff);
                  nc_ff    <= mm_pkg::clamp_dim(cols_cfg_ff);
                  r_ff     <= '0;
                  c_ff     <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               if (k_last) begin
                  k_ff     <= '0;
                  state_ff <= ST_WAIT;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            ST_WAIT: begin
               if (out_go) begin
                  if (col_last) begin
                     c_ff <= '0;
                     if (row_last) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        r_ff     <= r_ff + 1'b1;
                        state_ff <= ST_ISSUE;
                     end
                  end else begin
                     c_ff     <= c_ff + 1'b1;
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (int'(k_ff) < int'(nk_ff)))
      else $error("inner index past inner size");

   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> !(cmd.wr_left || cmd.wr_right))
      else $error("store write during product read");

   a_start_on_compute: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_IDLE) && (state_ff == ST_ISSUE)
         |-> $past(req_kind) == mm_pkg::KIND_COMPUTE)
      else $error("product started without compute item");

endmodule
`default_nettype wire

[sv/mm_datapath.sv]
`default_nettype none
module mm_datapath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mm_pkg::cmd_type             cmd,
   output mm_pkg::sts_type                  sts,
   input  wire logic [mm_pkg::DATA_W-1:0]   req_value,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [mm_pkg::TDATA_W-1:0]       rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   logic [mm_pkg::DATA_W-1:0]        left_rd, right_rd;
   logic                             s1_valid_ff, s1_first_ff, s1_last_ff;
   logic                             s2_valid_ff, s2_first_ff, s2_last_ff;
   logic signed [mm_pkg::PROD_W-1:0] prod_ff;
   logic signed [mm_pkg::ACC_W-1:0]  acc_ff, prod_ext;
   logic                             acc_valid_ff;
   logic signed [mm_pkg::ACC_W-1:0]  shifted;
   logic [mm_pkg::SH_W-1:0]          sh;
   logic [mm_pkg::SH_W-mm_pkg::DATA_W:0] hi;
   logic                             fits;
   logic [mm_pkg::DATA_W-1:0]        elem;
   logic                             rsp_valid_ff;

   mm_ram #(.WIDTH(mm_pkg::DATA_W), .DEPTH(mm_pkg::DEPTH)) u_left (
      .clock   (clock),
      .wr_en   (cmd.wr_left),
      .wr_addr (cmd.wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_left_addr),
      .rd_data (left_rd)
   );

   mm_ram #(.WIDTH(mm_pkg::DATA_W), .DEPTH(mm_pkg::DEPTH)) u_right (
      .clock   (clock),
      .wr_en   (cmd.wr_right),
      .wr_addr (cmd.wr_addr),
      .wr_data (req_value),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_right_addr),
      .rd_data (right_rd)
   );

   always_comb begin
      prod_ext = $signed({{(mm_pkg::ACC_W-mm_pkg::PROD_W){prod_ff[mm_pkg::PROD_W-1]}}, prod_ff});
      // floor of the exact sum
      shifted  = acc_ff >>> mm_pkg::FRAC_BITS;
      sh       = shifted[mm_pkg::SH_W-1:0];
      hi       = sh[mm_pkg::SH_W-1:mm_pkg::DATA_W-1];
      fits     = (&hi) || !(|hi);
      if (fits) begin
         elem = sh[mm_pkg::DATA_W-1:0];
      end else if (sh[mm_pkg::SH_W-1]) begin
         elem = {1'b1, {(mm_pkg::DATA_W-1){1'b0}}};
      end else begin
         elem = {1'b0, {(mm_pkg::DATA_W-1){1'b1}}};
      end
      sts.acc_valid = acc_valid_ff;
      sts.out_busy  = rsp_valid_ff && !rsp_tready;
      rsp_tvalid    = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff && s2_last_ff) begin
            acc_valid_ff <= 1'b1;
         end else if (cmd.out_load) begin
            acc_valid_ff <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_last_ff  <= cmd.last_k;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      prod_ff     <= $signed(left_rd) * $signed(right_rd);
      if (s2_valid_ff) begin
         acc_ff <= s2_first_ff ? prod_ext : acc_ff + prod_ext;
      end
      if (cmd.out_load) begin
         rsp_tdata <= {mm_pkg::PAD_W'(0), elem, cmd.out_col, cmd.out_row};
         rsp_tuser <= !fits;
         rsp_tlast <= cmd.out_last;
      end
   end

   a_load_needs_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> acc_valid_ff)
      else $error("result loaded before sum complete");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("held result overwritten");

   a_sum_done: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_last_ff |=> acc_valid_ff)
      else $error("finished sum not flagged");

endmodule
`default_nettype wire

[sv/matrix_multiply.sv]
`default_nettype none
// Fixed-point matrix multiply of up to MAX_DIM x MAX_DIM signed Q16.16
// matrices. Load items (tuser 0 left, 1 right) write one element. A compute
// item (tuser 2) streams left_rows x right_cols product elements in
// row-major order, tlast on the final one, tuser set when an element was
// clipped. Each element takes one store read per inner term through a
// single shared 32x32 multiplier, then passes the read, multiply and
// accumulate registers; the next element starts as soon as the previous one
// sits in the output register. No new item is accepted until the last
// product element sits in the output register. Size registers are read at
// the start of each compute item.
module matrix_multiply (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mm_pkg::TDATA_W-1:0]      req_tdata,  // row, col, value
   input  wire logic [mm_pkg::KIND_W-1:0]       req_tuser,  // kind
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [mm_pkg::TDATA_W-1:0]           rsp_tdata,  // out_row, out_col, out_value
   output logic                                 rsp_tuser,  // saturated
   output logic                                 rsp_tlast,
   input  wire logic                            csr_we,
   input  wire logic [mm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mm_pkg::CFG_W-1:0]        csr_wdata
);

   mm_pkg::cmd_type cmd;
   mm_pkg::sts_type sts;

   mm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_row    (req_tdata[mm_pkg::POS_W-1:0]),
      .req_col    (req_tdata[2*mm_pkg::POS_W-1:mm_pkg::POS_W]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .sts        (sts),
      .cmd        (cmd)
   );

   mm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_value  (req_tdata[mm_pkg::ITEM_BITS-1:2*mm_pkg::POS_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[tb/sv/matrix_multiply_test.sv]
module matrix_multiply_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mm_pkg::*;

   localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 2'd3;
   localparam int DRAIN_CYCLES = 24;
   localparam logic signed [ACC_W+1:0] SAT_HI = 32'sh7FFF_FFFF;
   localparam logic signed [ACC_W+1:0] SAT_LO = 32'sh8000_0000;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } mm_cmd_type;

   typedef struct {
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              sat;
      logic              is_last;
   } mm_elem_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [TDATA_W-1:0]   req_tdata = '0;   // row, col, value
   logic [KIND_W-1:0]    req_tuser = '0;   // kind
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [TDATA_W-1:0]   rsp_tdata;        // out_row, out_col, out_value
   logic                 rsp_tuser;        // saturated
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   matrix_multiply i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   mm_cmd_type  mm_cmds[$];
   mm_elem_type product_elems[$];

   // predictor copy of the stores and size registers
   logic [DATA_W-1:0] left_elems[DEPTH];
   logic [DATA_W-1:0] right_elems[DEPTH];
   logic [CFG_W-1:0]  cur_rows  = CFG_RESET;
   logic [CFG_W-1:0]  cur_inner = CFG_RESET;
   logic [CFG_W-1:0]  cur_cols  = CFG_RESET;

   // stimulus-side view: sizes last written, entries loaded so far
   logic [CFG_W-1:0]  gen_rows  = CFG_RESET;
   logic [CFG_W-1:0]  gen_inner = CFG_RESET;
   logic [CFG_W-1:0]  gen_cols  = CFG_RESET;
   logic [DEPTH-1:0]  left_loaded  = '0;
   logic [DEPTH-1:0]  right_loaded = '0;

   int req_gap_max   = 0;
   int rsp_stall_max = 0;
   int req_gap       = 0;
   int rsp_stall     = 0;
   bit rsp_hold      = 1'b0;
   bit req_took      = 1'b0;
   bit rsp_took      = 1'b0;
   int mismatches    = 0;
   int issued        = 0;

   function automatic int dim_used(logic [CFG_W-1:0] d);
      if (d == '0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   function automatic void predict_product();
      int nr, nk, nc;
      logic signed [ACC_W+1:0] acc, scaled;
      longint a, b;
      mm_elem_type e;
      nr = dim_used(cur_rows);
      nk = dim_used(cur_inner);
      nc = dim_used(cur_cols);
      for (int r = 0; r < nr; r++) begin
         for (int c = 0; c < nc; c++) begin
            acc = '0;
            for (int k = 0; k < nk; k++) begin
               a = $signed(left_elems[r*MAX_DIM+k]);
               b = $signed(right_elems[k*MAX_DIM+c]);
               acc = acc + a * b;
            end
            // floor division by 2^FRAC_BITS
            scaled = acc >>> FRAC_BITS;
            e.row = POS_W'(r);
            e.col = POS_W'(c);
            e.sat = 1'b1;
            if (scaled > SAT_HI) begin
               e.value = 32'h7FFF_FFFF;
            end else if (scaled < SAT_LO) begin
               e.value = 32'h8000_0000;
            end else begin
               e.value = scaled[DATA_W-1:0];
               e.sat = 1'b0;
            end
            e.is_last = (r == nr - 1) && (c == nc - 1);
            product_elems = {product_elems, e};
         end
      end
   endfunction

   task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      mm_elem_type want;
      int idx;
      req_took = !reset && req_tvalid && req_tready;
      rsp_took = !reset && rsp_tvalid && rsp_tready;
      if (reset) begin
         cur_rows  = CFG_RESET;
         cur_inner = CFG_RESET;
         cur_cols  = CFG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_LEFT_ROWS:  cur_rows  = csr_wdata;
            REG_INNER_SIZE: cur_inner = csr_wdata;
            REG_RIGHT_COLS: cur_cols  = csr_wdata;
            default: ;
         endcase
      end
      if (req_took) begin
         idx = int'(req_tdata[POS_W-1:0]) * MAX_DIM + int'(req_tdata[2*POS_W-1:POS_W]);
         case (req_tuser)
            KIND_LOAD_LEFT:  left_elems[idx]  = req_tdata[2*POS_W+DATA_W-1:2*POS_W];
            KIND_LOAD_RIGHT: right_elems[idx] = req_tdata[2*POS_W+DATA_W-1:2*POS_W];
            KIND_COMPUTE:    predict_product();
            default: ;
         endcase
      end
      if (rsp_took) begin
         if (product_elems.size() == 0) begin
            flag_mismatch("unexpected item", rsp_tdata[2*POS_W+DATA_W-1:2*POS_W], '0);
         end else begin
            want = product_elems.pop_front();
            if (rsp_tdata[POS_W-1:0] !== want.row)
               flag_mismatch("out_row", DATA_W'(rsp_tdata[POS_W-1:0]), DATA_W'(want.row));
            if (rsp_tdata[2*POS_W-1:POS_W] !== want.col)
               flag_mismatch("out_col", DATA_W'(rsp_tdata[2*POS_W-1:POS_W]),
                             DATA_W'(want.col));
            if (rsp_tdata[2*POS_W+DATA_W-1:2*POS_W] !== want.value)
               flag_mismatch("out_value", rsp_tdata[2*POS_W+DATA_W-1:2*POS_W], want.value);
            if (rsp_tuser !== want.sat)
               flag_mismatch("saturated", DATA_W'(rsp_tuser), DATA_W'(want.sat));
            if (rsp_tlast !== want.is_last)
               flag_mismatch("last", DATA_W'(rsp_tlast), DATA_W'(want.is_last));
         end
      end
   end

   always @(negedge clock) begin : drive_req
      logic nxt_valid;
      mm_cmd_type cur;
      nxt_valid = 1'b0;
      if (req_took) begin
         mm_cmds.delete(0);
         req_gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      end
      if (req_gap > 0) begin
         req_gap--;
      end else if (!reset && mm_cmds.size() != 0) begin
         cur = mm_cmds[0];
         nxt_valid = 1'b1;
         req_tdata <= {{PAD_W{1'b0}}, cur.value, cur.col, cur.row};
         req_tuser <= cur.kind;
      end
      req_tvalid <= nxt_valid;
   end

   always @(negedge clock) begin : drive_rsp
      if (rsp_took)
         rsp_stall = (rsp_stall_max == 0) ? 0 : $urandom_range(0, rsp_stall_max);
      if (reset || rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [DATA_W-1:0] rand_value();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return DATA_W'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
      if (pick < 85) return $urandom;
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'h0000_0001;
         4:       return 32'hFFFF_FFFF;
         default: return 32'h0001_0000;
      endcase
   endfunction

   task automatic push_cmd(logic [KIND_W-1:0] kind, int row, int col, logic [DATA_W-1:0] value);
      mm_cmd_type c;
      c.kind  = kind;
      c.row   = POS_W'(row);
      c.col   = POS_W'(col);
      c.value = value;
      mm_cmds = {mm_cmds, c};
      if (kind == KIND_LOAD_LEFT) left_loaded[row*MAX_DIM+col] = 1'b1;
      else if (kind == KIND_LOAD_RIGHT) right_loaded[row*MAX_DIM+col] = 1'b1;
      issued++;
   endtask

   // fill any entry the product will read that was never loaded, then compute
   task automatic push_compute();
      int nr, nk, nc;
      nr = dim_used(gen_rows);
      nk = dim_used(gen_inner);
      nc = dim_used(gen_cols);
      for (int r = 0; r < nr; r++)
         for (int k = 0; k < nk; k++)
            if (!left_loaded[r*MAX_DIM+k]) push_cmd(KIND_LOAD_LEFT, r, k, rand_value());
      for (int k = 0; k < nk; k++)
         for (int c = 0; c < nc; c++)
            if (!right_loaded[k*MAX_DIM+c]) push_cmd(KIND_LOAD_RIGHT, k, c, rand_value());
      push_cmd(KIND_COMPUTE, $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
   endtask

   task automatic push_load();
      push_cmd(($urandom_range(0, 1) != 0) ? KIND_LOAD_RIGHT : KIND_LOAD_LEFT,
               $urandom_range(0, 3), $urandom_range(0, 3), rand_value());
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_sizes(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                            logic [CFG_W-1:0] cols);
      write_csr(REG_LEFT_ROWS, rows);
      write_csr(REG_INNER_SIZE, inner);
      write_csr(REG_RIGHT_COLS, cols);
      gen_rows  = rows;
      gen_inner = inner;
      gen_cols  = cols;
   endtask

   task automatic drain();
      while (mm_cmds.size() != 0 || product_elems.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) push_cmd(KIND_UNUSED, $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
         else if (pick < 26) push_compute();
         else push_load();
      end
      push_compute();
   endtask

   initial begin : run
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-term products: saturation both ways, floor rounding, ignored kind
      set_sizes(3'd1, 3'd1, 3'd1);
      push_cmd(KIND_LOAD_LEFT, 0, 0, 32'h7FFF_FFFF);
      push_cmd(KIND_LOAD_RIGHT, 0, 0, 32'h7FFF_FFFF);
      push_cmd(KIND_COMPUTE, 0, 0, 32'h0000_0000);
      push_cmd(KIND_LOAD_LEFT, 0, 0, 32'h8000_0000);
      push_cmd(KIND_COMPUTE, 3, 3, 32'hFFFF_FFFF);
      push_cmd(KIND_LOAD_RIGHT, 0, 0, 32'h8000_0000);
      push_cmd(KIND_COMPUTE, 0, 0, 32'h0000_0000);
      push_cmd(KIND_LOAD_LEFT, 0, 0, 32'h0001_0000);
      push_cmd(KIND_LOAD_RIGHT, 0, 0, 32'hFFFF_FFFF);
      push_cmd(KIND_COMPUTE, 0, 0, 32'h0000_0000);
      push_cmd(KIND_LOAD_LEFT, 0, 0, 32'h0000_0001);
      push_cmd(KIND_COMPUTE, 0, 0, 32'h0000_0000);
      push_cmd(KIND_LOAD_RIGHT, 0, 0, 32'h0000_0001);
      push_cmd(KIND_COMPUTE, 0, 0, 32'h0000_0000);
      push_cmd(KIND_UNUSED, 3, 3, 32'hFFFF_FFFF);
      push_cmd(KIND_LOAD_LEFT, 3, 3, 32'h0000_0000);
      push_cmd(KIND_LOAD_RIGHT, 3, 3, 32'hFFFF_FFFF);
      push_cmd(KIND_COMPUTE, 0, 0, 32'h0000_0000);
      drain();

      // zero sizes act as 1, sizes above the maximum act as the maximum
      set_sizes(3'd0, 3'd0, 3'd0);
      push_compute();
      drain();
      write_csr(REG_UNUSED, 3'd5);
      set_sizes(3'd7, 3'd7, 3'd7);
      push_compute();
      drain();
      set_sizes(3'd4, 3'd1, 3'd4);
      push_compute();
      drain();
      set_sizes(3'd1, 3'd4, 3'd1);
      push_compute();
      drain();

      // receiver holds off long enough for the block to back up its input
      set_sizes(3'd4, 3'd4, 3'd4);
      fork
         begin
            rsp_hold = 1'b1;
            repeat (600) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      repeat (4) begin
         push_load();
         push_compute();
      end
      drain();

      while (issued < 260) begin
         set_sizes($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0: begin req_gap_max = 0;  rsp_stall_max = 0;  end
            1: begin req_gap_max = 15; rsp_stall_max = 0;  end
            2: begin req_gap_max = 0;  rsp_stall_max = 15; end
            default: begin req_gap_max = 15; rsp_stall_max = 15; end
         endcase
         random_phase(30);
         drain();
      end

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
